@@ rtl/core/tli_pkg.sv @@
// Shared types and constants for the table linear interpolator.
`timescale 1ns / 1ps

package tli_pkg;

	localparam int ANGLE_W = 20;
	localparam int COEF_W  = 16;
	localparam int IDX_W   = 6;
	localparam int COUNT_W = 7;
	localparam int ENTRY_W = ANGLE_W + 2 * COEF_W;
	localparam int PROD_W  = ANGLE_W + COEF_W;
	localparam int DIV_CNT_W = $clog2(COEF_W);

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic [1:0] REG_ENTRY_COUNT = 2'd0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIRST,
		ST_SCAN,
		ST_MUL,
		ST_DIV,
		ST_WAIT,
		ST_EMIT
	} tli_state_t;

	typedef struct packed {
		logic wr;
		logic q_ld;
		logic rd;
		logic seg_ld;
		logic mul;
		logic div_go;
		logic res_st;
		logic res_clr;
		logic sel_drag;
	} tli_cmd_t;

	typedef struct packed {
		logic hit;
		logic div_done;
	} tli_sts_t;

endpackage

@@ rtl/core/table_linear_interpolator_unit.sv @@
// Top level of the table linear interpolator: config register and unit wiring.
`timescale 1ns / 1ps

// Breakpoint table with piecewise-linear interpolation of lift and drag.
// Input words are issued with start while busy is low. mode = load writes
// entry entry_index (angle, lift_value, drag_value) in the accepting cycle and
// produces no result; busy stays low. mode = query scans the first
// entry_count entries for angle[i] <= angle < angle[i+1] and returns one
// result word, shown for one cycle with done, on lift_out, drag_out, in_range.
// A hit runs from the accepting edge to done through one priming read, a scan
// of k segments (k = segments examined, at most depth-1, one memory read per
// cycle), the blend (one shared 16-step divider runs once for lift and once
// for drag) and the done cycle. A miss returns zeros with in_range low after
// the priming read and the scan; fewer than two entries go straight to done.
// busy drops in the cycle after done, so the next word can follow at once.
// entry_count sits at APB byte address 0; write it only while idle.
// Reset clears the controller, entry_count and the result ports; the table
// contents are undefined until loaded and need no clearing pass.
// The receiver cannot stall: each result is valid only in its done cycle.

module table_linear_interpolator_unit import tli_pkg::*; #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [1:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  logic                      start,
	output logic                      busy,
	input  logic                      mode,
	input  logic [IDX_W-1:0]          entry_index,
	input  logic signed [ANGLE_W-1:0] angle,
	input  logic signed [COEF_W-1:0]  lift_value,
	input  logic signed [COEF_W-1:0]  drag_value,
	output logic                      done,
	output logic signed [COEF_W-1:0]  lift_out,
	output logic signed [COEF_W-1:0]  drag_out,
	output logic                      in_range
);

	localparam int ADDR_W = $clog2(TABLE_DEPTH);

	logic [COUNT_W-1:0] entry_count_q;
	tli_cmd_t           cmd;
	tli_sts_t           sts;
	logic [ADDR_W-1:0]  rd_addr;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (psel && penable && pwrite && paddr == REG_ENTRY_COUNT) begin
			entry_count_q <= pwdata[COUNT_W-1:0];
		end
	end

	assign prdata = (paddr == REG_ENTRY_COUNT) ? 32'(entry_count_q) : '0;

	tli_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.mode        (mode),
		.entry_count (entry_count_q),
		.sts         (sts),
		.cmd         (cmd),
		.rd_addr     (rd_addr),
		.busy        (busy),
		.done        (done)
	);

	tli_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.rd_addr     (rd_addr),
		.entry_index (entry_index),
		.angle       (angle),
		.lift_value  (lift_value),
		.drag_value  (drag_value),
		.lift_out    (lift_out),
		.drag_out    (drag_out),
		.in_range    (in_range)
	);

endmodule

@@ rtl/core/tli_div.sv @@
// Restoring divider, one quotient bit per cycle, quotient known to fit COEF_W bits.
`timescale 1ns / 1ps

module tli_div import tli_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [PROD_W-1:0]   dividend,
	input  logic [ANGLE_W-1:0]  divisor,
	output logic [COEF_W-1:0]   quot,
	output logic                done
);

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [ANGLE_W-1:0]    rem_q;
	logic [COEF_W-1:0]     quo_q;
	logic [ANGLE_W:0]      trial;
	logic [ANGLE_W:0]      diff;
	logic                  fits;

	// dividend < divisor * 2^COEF_W, so the upper part starts below the divisor
	assign trial = {rem_q, quo_q[COEF_W-1]};
	assign fits  = (trial >= {1'b0, divisor});
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(COEF_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[PROD_W-1 -: ANGLE_W];
			quo_q <= dividend[COEF_W-1:0];
		end else if (busy_q) begin
			rem_q <= fits ? diff[ANGLE_W-1:0] : trial[ANGLE_W-1:0];
			quo_q <= {quo_q[COEF_W-2:0], fits};
		end
	end

	assign quot = quo_q;
	assign done = done_q;

endmodule

@@ rtl/core/tli_datapath.sv @@
// Datapath: breakpoint memory, segment compare, multiply and divide for the blend.
`timescale 1ns / 1ps

module tli_datapath import tli_pkg::*; #(
	parameter int TABLE_DEPTH = 64,
	localparam int ADDR_W = $clog2(TABLE_DEPTH)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tli_cmd_t                  cmd,
	output tli_sts_t                  sts,
	input  logic [ADDR_W-1:0]         rd_addr,
	input  logic [IDX_W-1:0]          entry_index,
	input  logic signed [ANGLE_W-1:0] angle,
	input  logic signed [COEF_W-1:0]  lift_value,
	input  logic signed [COEF_W-1:0]  drag_value,
	output logic signed [COEF_W-1:0]  lift_out,
	output logic signed [COEF_W-1:0]  drag_out,
	output logic                      in_range
);

	logic [ENTRY_W-1:0]        mem_q [TABLE_DEPTH];
	logic [ENTRY_W-1:0]        rd_data_q;
	logic [ENTRY_W-1:0]        prev_q;
	logic signed [ANGLE_W-1:0] qang_q;

	logic [ANGLE_W-1:0]        span_q;
	logic [ANGLE_W-1:0]        offset_q;
	logic signed [COEF_W-1:0]  lo_lift_q;
	logic signed [COEF_W-1:0]  lo_drag_q;
	logic signed [COEF_W:0]    dlift_q;
	logic signed [COEF_W:0]    ddrag_q;
	logic [PROD_W-1:0]         prod_q;
	logic                      neg_q;

	logic signed [COEF_W-1:0]  lift_res_q;
	logic signed [COEF_W-1:0]  drag_res_q;
	logic                      in_range_q;

	logic                      wr_ok;
	logic [ADDR_W-1:0]         wr_addr;
	logic signed [ANGLE_W-1:0] lo_ang;
	logic signed [ANGLE_W-1:0] hi_ang;
	logic signed [COEF_W-1:0]  lo_lift;
	logic signed [COEF_W-1:0]  hi_lift;
	logic signed [COEF_W-1:0]  lo_drag;
	logic signed [COEF_W-1:0]  hi_drag;
	logic signed [ANGLE_W:0]   span_d;
	logic signed [ANGLE_W:0]   offset_d;
	logic signed [COEF_W:0]    dsel;
	logic signed [COEF_W:0]    mag_w;
	logic [COEF_W-1:0]         mag;
	logic [PROD_W-1:0]         prod_d;
	logic [COEF_W-1:0]         quot;
	logic                      div_done;
	logic signed [COEF_W:0]    quot_s;
	logic signed [COEF_W:0]    lo_sel;
	logic signed [COEF_W:0]    sum;

	assign wr_ok   = (32'(entry_index) < 32'(TABLE_DEPTH));
	assign wr_addr = ADDR_W'(entry_index);

	always_ff @(posedge clk) begin
		if (cmd.wr && wr_ok) begin
			mem_q[wr_addr] <= {angle, lift_value, drag_value};
		end
		if (cmd.rd) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// entry layout: {angle, lift, drag}
	assign lo_ang  = signed'(prev_q[ENTRY_W-1 -: ANGLE_W]);
	assign hi_ang  = signed'(rd_data_q[ENTRY_W-1 -: ANGLE_W]);
	assign lo_lift = signed'(prev_q[2*COEF_W-1 -: COEF_W]);
	assign hi_lift = signed'(rd_data_q[2*COEF_W-1 -: COEF_W]);
	assign lo_drag = signed'(prev_q[COEF_W-1:0]);
	assign hi_drag = signed'(rd_data_q[COEF_W-1:0]);

	assign sts.hit = (qang_q >= lo_ang) && (qang_q < hi_ang);

	assign span_d   = {hi_ang[ANGLE_W-1], hi_ang} - {lo_ang[ANGLE_W-1], lo_ang};
	assign offset_d = {qang_q[ANGLE_W-1], qang_q} - {lo_ang[ANGLE_W-1], lo_ang};

	always_ff @(posedge clk) begin
		if (cmd.q_ld) begin
			qang_q <= angle;
		end
		if (cmd.rd) begin
			prev_q <= rd_data_q;
		end
		if (cmd.seg_ld) begin
			span_q    <= span_d[ANGLE_W-1:0];
			offset_q  <= offset_d[ANGLE_W-1:0];
			lo_lift_q <= lo_lift;
			lo_drag_q <= lo_drag;
			dlift_q   <= {hi_lift[COEF_W-1], hi_lift} - {lo_lift[COEF_W-1], lo_lift};
			ddrag_q   <= {hi_drag[COEF_W-1], hi_drag} - {lo_drag[COEF_W-1], lo_drag};
		end
		if (cmd.mul) begin
			prod_q <= prod_d;
			neg_q  <= dsel[COEF_W];
		end
	end

	// |delta| * offset, sign reapplied after the divide (truncates toward zero)
	assign dsel   = cmd.sel_drag ? ddrag_q : dlift_q;
	assign mag_w  = dsel[COEF_W] ? -dsel : dsel;
	assign mag    = mag_w[COEF_W-1:0];
	assign prod_d = PROD_W'(mag) * PROD_W'(offset_q);

	tli_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_go),
		.dividend (prod_q),
		.divisor  (span_q),
		.quot     (quot),
		.done     (div_done)
	);

	assign sts.div_done = div_done;

	assign quot_s = neg_q ? -signed'({1'b0, quot}) : signed'({1'b0, quot});
	assign lo_sel = cmd.sel_drag ? {lo_drag_q[COEF_W-1], lo_drag_q}
	                             : {lo_lift_q[COEF_W-1], lo_lift_q};
	assign sum    = lo_sel + quot_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lift_res_q <= '0;
			drag_res_q <= '0;
			in_range_q <= 1'b0;
		end else begin
			if (cmd.res_clr) begin
				lift_res_q <= '0;
				drag_res_q <= '0;
				in_range_q <= 1'b0;
			end else begin
				if (cmd.seg_ld) begin
					in_range_q <= 1'b1;
				end
				if (cmd.res_st && !cmd.sel_drag) begin
					lift_res_q <= sum[COEF_W-1:0];
				end
				if (cmd.res_st && cmd.sel_drag) begin
					drag_res_q <= sum[COEF_W-1:0];
				end
			end
		end
	end

	assign lift_out = lift_res_q;
	assign drag_out = drag_res_q;
	assign in_range = in_range_q;

endmodule

@@ rtl/core/tli_ctrl.sv @@
// Controller: sequences load, table scan, the two blends and the result strobe.
`timescale 1ns / 1ps

module tli_ctrl import tli_pkg::*; #(
	parameter int TABLE_DEPTH = 64,
	localparam int ADDR_W = $clog2(TABLE_DEPTH),
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                mode,
	input  logic [COUNT_W-1:0]  entry_count,
	input  tli_sts_t            sts,
	output tli_cmd_t            cmd,
	output logic [ADDR_W-1:0]   rd_addr,
	output logic                busy,
	output logic                done
);

	localparam int EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

	tli_state_t        state_q, state_d;
	logic [CNT_W-1:0]  addr_q, addr_d;
	logic              sel_q, sel_d;
	logic [EXT_W-1:0]  cnt_ext;
	logic [CNT_W-1:0]  count_eff;

	// counts above the depth saturate
	assign cnt_ext   = EXT_W'(entry_count);
	assign count_eff = (cnt_ext > EXT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
	                                                  : CNT_W'(cnt_ext);

	assign rd_addr = (state_q == ST_IDLE) ? '0 : addr_q[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			addr_q  <= '0;
			sel_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			addr_q  <= addr_d;
			sel_q   <= sel_d;
		end
	end

	always_comb begin
		state_d = state_q;
		addr_d  = addr_q;
		sel_d   = sel_q;
		cmd     = '0;
		busy    = 1'b1;
		done    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (mode == MODE_LOAD) begin
						cmd.wr = 1'b1;
					end else begin
						cmd.q_ld = 1'b1;
						cmd.rd   = 1'b1;
						addr_d   = CNT_W'(1);
						if (count_eff < CNT_W'(2)) begin
							cmd.res_clr = 1'b1;
							state_d     = ST_EMIT;
						end else begin
							state_d = ST_FIRST;
						end
					end
				end
			end
			ST_FIRST: begin
				cmd.rd  = 1'b1;
				addr_d  = addr_q + CNT_W'(1);
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				// prev word is entry addr_q-2, read word is entry addr_q-1
				if (sts.hit) begin
					cmd.seg_ld = 1'b1;
					sel_d      = 1'b0;
					state_d    = ST_MUL;
				end else if (addr_q == count_eff) begin
					cmd.res_clr = 1'b1;
					state_d     = ST_EMIT;
				end else begin
					cmd.rd = 1'b1;
					addr_d = addr_q + CNT_W'(1);
				end
			end
			ST_MUL: begin
				cmd.mul      = 1'b1;
				cmd.sel_drag = sel_q;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_go = 1'b1;
				state_d    = ST_WAIT;
			end
			ST_WAIT: begin
				cmd.sel_drag = sel_q;
				if (sts.div_done) begin
					cmd.res_st = 1'b1;
					if (sel_q) begin
						state_d = ST_EMIT;
					end else begin
						sel_d   = 1'b1;
						state_d = ST_MUL;
					end
				end
			end
			ST_EMIT: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode == MODE_QUERY) |=> busy)
		else $error("accepted query did not start work");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode == MODE_LOAD) |=> (!busy && !done))
		else $error("load word left the controller busy");

	a_wait_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT && !sts.div_done) |=> (state_q == ST_WAIT))
		else $error("left divide wait without done");

endmodule

@@ sim/table_linear_interpolator_unit_tb.sv @@
// Self-checking testbench for the table linear interpolator unit.
`timescale 1ns / 1ps

module table_linear_interpolator_unit_tb;
	import tli_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam int ANG_MIN     = -(1 << (ANGLE_W - 1));
	localparam int ANG_MAX     = (1 << (ANGLE_W - 1)) - 1;
	localparam int COEF_MIN    = -(1 << (COEF_W - 1));
	localparam int COEF_MAX    = (1 << (COEF_W - 1)) - 1;
	localparam int ITEM_TARGET = 1800;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 120;

	typedef struct packed {
		logic signed [COEF_W-1:0] lift;
		logic signed [COEF_W-1:0] drag;
		logic                     hit;
	} blend_t;

	logic                      clk;
	logic                      arst_n;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [1:0]                paddr;
	logic [31:0]               pwdata;
	logic [31:0]               prdata;
	logic                      pready;
	logic                      start;
	logic                      busy;
	logic                      mode;
	logic [IDX_W-1:0]          entry_index;
	logic signed [ANGLE_W-1:0] angle;
	logic signed [COEF_W-1:0]  lift_value;
	logic signed [COEF_W-1:0]  drag_value;
	logic                      done;
	logic signed [COEF_W-1:0]  lift_out;
	logic signed [COEF_W-1:0]  drag_out;
	logic                      in_range;

	// shadow of the breakpoint table and the count register
	logic signed [ANGLE_W-1:0] tbl_angle [TABLE_DEPTH];
	logic signed [COEF_W-1:0]  tbl_lift  [TABLE_DEPTH];
	logic signed [COEF_W-1:0]  tbl_drag  [TABLE_DEPTH];
	logic [COUNT_W-1:0]        cfg_count;

	blend_t blend_due_q [$];
	int     err_count;
	int     item_count;
	int     gap_max;
	int     stall_cycles;

	table_linear_interpolator_unit #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.entry_index(entry_index),
		.angle      (angle),
		.lift_value (lift_value),
		.drag_value (drag_value),
		.done       (done),
		.lift_out   (lift_out),
		.drag_out   (drag_out),
		.in_range   (in_range)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int rand_between(input int lo, input int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	function automatic int rand_coef();
		case ($urandom_range(0, 9))
			0: return COEF_MIN;
			1: return COEF_MAX;
			default: return rand_between(COEF_MIN, COEF_MAX);
		endcase
	endfunction

	function automatic logic signed [COEF_W-1:0] lerp_coef(input longint lo, input longint hi,
			input longint offs, input longint span);
		// signed division truncates toward zero
		return COEF_W'(lo + ((hi - lo) * offs) / span);
	endfunction

	// first segment with a[i] <= q < a[i+1] among the valid entries
	function automatic blend_t blend_coeffs(input logic signed [ANGLE_W-1:0] q);
		blend_t r;
		int     eff;
		longint a0;
		longint a1;
		longint qv;
		r   = '0;
		qv  = longint'(q);
		eff = (cfg_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(cfg_count);
		for (int i = 0; i + 1 < eff; i++) begin
			a0 = longint'(tbl_angle[i]);
			a1 = longint'(tbl_angle[i+1]);
			if (qv >= a0 && qv < a1) begin
				r.lift = lerp_coef(longint'(tbl_lift[i]), longint'(tbl_lift[i+1]),
					qv - a0, a1 - a0);
				r.drag = lerp_coef(longint'(tbl_drag[i]), longint'(tbl_drag[i+1]),
					qv - a0, a1 - a0);
				r.hit  = 1'b1;
				break;
			end
		end
		return r;
	endfunction

	function automatic int pick_query_angle(input int n);
		int i;
		int a0;
		int a1;
		if (n < 2)
			return rand_between(ANG_MIN, ANG_MAX);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				i  = rand_between(0, n - 2);
				a0 = int'(tbl_angle[i]);
				a1 = int'(tbl_angle[i+1]);
				return (a1 > a0) ? rand_between(a0, a1 - 1) : a0;
			end
			6: return int'(tbl_angle[rand_between(0, n - 1)]);
			7: return rand_between(ANG_MIN, int'(tbl_angle[0]));
			8: return rand_between(int'(tbl_angle[n-1]), ANG_MAX);
			default: return rand_between(ANG_MIN, ANG_MAX);
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $realtime, what);
		err_count++;
	endtask

	// one input word; start stays high when the next word follows with no gap
	task automatic send_word(input logic m, input int idx, input int ang, input int lv,
			input int dv);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		mode        <= m;
		entry_index <= idx[IDX_W-1:0];
		angle       <= ang[ANGLE_W-1:0];
		lift_value  <= lv[COEF_W-1:0];
		drag_value  <= dv[COEF_W-1:0];
		@(posedge clk);
		while (busy) @(posedge clk);
		item_count++;
		if (m == MODE_LOAD) begin
			tbl_angle[idx[IDX_W-1:0]] = ang[ANGLE_W-1:0];
			tbl_lift[idx[IDX_W-1:0]]  = lv[COEF_W-1:0];
			tbl_drag[idx[IDX_W-1:0]]  = dv[COEF_W-1:0];
		end else begin
			blend_due_q.insert(blend_due_q.size(), blend_coeffs(ang[ANGLE_W-1:0]));
		end
	endtask

	task automatic query_angle(input int ang);
		send_word(MODE_QUERY, rand_between(0, TABLE_DEPTH - 1), ang,
			rand_between(COEF_MIN, COEF_MAX), rand_between(COEF_MIN, COEF_MAX));
	endtask

	task automatic settle_block();
		start <= 1'b0;
		while (blend_due_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_entry_count(input int value);
		logic [31:0] wd;
		settle_block();
		wd                = $urandom;
		wd[COUNT_W-1:0]   = value[COUNT_W-1:0];
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_ENTRY_COUNT;
		pwdata  <= wd;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cfg_count = wd[COUNT_W-1:0];
	endtask

	// loads entries 0..n-1; ordered tables ascend with an occasional repeated angle
	task automatic build_table(input int n, input bit ordered);
		int maxstep;
		int full;
		int a;
		full = (ANG_MAX - ANG_MIN) / (n - 1);
		case ($urandom_range(0, 3))
			0: maxstep = 3;
			1: maxstep = 300;
			2: maxstep = 20000;
			default: maxstep = full;
		endcase
		if (maxstep > full)
			maxstep = full;
		a = rand_between(ANG_MIN, ANG_MAX - (n - 1) * maxstep);
		for (int i = 0; i < n; i++) begin
			send_word(MODE_LOAD, i, ordered ? a : rand_between(ANG_MIN, ANG_MAX),
				rand_coef(), rand_coef());
			a += ($urandom_range(0, 15) == 0) ? 0 : rand_between(1, maxstep);
		end
	endtask

	// empty and single-entry tables never bracket
	task automatic test_short_tables();
		gap_max = 17;
		send_word(MODE_LOAD, 0, ANG_MIN, COEF_MIN, COEF_MAX);
		send_word(MODE_LOAD, 1, ANG_MAX, COEF_MAX, COEF_MIN);
		query_angle(0);
		query_angle(ANG_MIN);
		write_entry_count(1);
		query_angle(0);
		query_angle(ANG_MIN);
	endtask

	// widest possible segment with full-scale coefficient swings
	task automatic test_extreme_segment();
		write_entry_count(2);
		query_angle(ANG_MIN);
		query_angle(ANG_MAX - 1);
		query_angle(ANG_MAX);
		query_angle(0);
		query_angle(-1);
		query_angle(1);
	endtask

	task automatic test_unordered_table();
		gap_max = 0;
		send_word(MODE_LOAD, 0, 500, 4096, -4096);
		send_word(MODE_LOAD, 1, -500, -4096, 4096);
		query_angle(0);
		query_angle(500);
		query_angle(-500);
		send_word(MODE_LOAD, 1, 500, 100, 200);
		query_angle(500);
	endtask

	// count above the depth saturates at a full table
	task automatic test_full_table();
		gap_max = 17;
		build_table(TABLE_DEPTH, 1'b1);
		write_entry_count((1 << COUNT_W) - 1);
		repeat (12) query_angle(pick_query_angle(TABLE_DEPTH));
		write_entry_count(TABLE_DEPTH);
		repeat (8) query_angle(pick_query_angle(TABLE_DEPTH));
	endtask

	task automatic test_random_phases();
		int cnt;
		int eff;
		int n_built;
		int j;
		while (item_count < ITEM_TARGET) begin
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
			case ($urandom_range(0, 19))
				0: cnt = 0;
				1: cnt = 1;
				2: cnt = rand_between(TABLE_DEPTH + 1, (1 << COUNT_W) - 1);
				3: cnt = TABLE_DEPTH;
				4, 5, 6, 7, 8, 9: cnt = rand_between(2, 4);
				10, 11, 12, 13, 14, 15, 16, 17: cnt = rand_between(5, 12);
				default: cnt = rand_between(13, TABLE_DEPTH - 1);
			endcase
			eff     = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;
			n_built = (eff < 2) ? 2 : eff;
			write_entry_count(cnt);
			build_table(n_built, $urandom_range(0, 19) < 17);
			repeat (rand_between(3, 24)) begin
				case ($urandom_range(0, 29))
					0, 1: begin
						j = rand_between(0, n_built - 1);
						send_word(MODE_LOAD, j,
							($urandom_range(0, 2) == 0) ? rand_between(ANG_MIN, ANG_MAX)
								: int'(tbl_angle[j]),
							rand_coef(), rand_coef());
					end
					2: settle_block();
					default: query_angle(pick_query_angle(eff));
				endcase
			end
		end
	endtask

	always @(posedge clk) begin : check_results
		blend_t want;
		if (arst_n && done) begin
			if (blend_due_q.size() == 0) begin
				report_mismatch($sformatf("result word with none due: lift %0d drag %0d hit %0b",
					lift_out, drag_out, in_range));
			end else begin
				want = blend_due_q.pop_front();
				if (lift_out !== want.lift)
					report_mismatch($sformatf("lift_out %0d, want %0d", lift_out, want.lift));
				if (drag_out !== want.drag)
					report_mismatch($sformatf("drag_out %0d, want %0d", drag_out, want.drag));
				if (in_range !== want.hit)
					report_mismatch($sformatf("in_range %0b, want %0b", in_range, want.hit));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (psel && penable && pwrite && pready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Watchdog: no activity for %0d cycles", STALL_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		start        = 1'b0;
		mode         = MODE_LOAD;
		entry_index  = '0;
		angle        = '0;
		lift_value   = '0;
		drag_value   = '0;
		cfg_count    = '0;
		err_count    = 0;
		item_count   = 0;
		gap_max      = 17;
		stall_cycles = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_short_tables();
		test_extreme_segment();
		test_unordered_table();
		test_full_table();
		test_random_phases();

		settle_block();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
